// ===== rtl/matrix_vector_multiply_unit_macros.svh =====
// Assertion macros shared by the matrix-vector multiply unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MVMU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("matrix_vector_multiply_unit: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MVMU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("matrix_vector_multiply_unit: assertion failed");

`endif

// ===== rtl/mvmu_pkg.sv =====
// Shared constants, codes and types of the matrix-vector multiply unit.
// Used by mvmu_cell and matrix_vector_multiply_unit; depends on nothing.
package mvmu_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int VALUE_WIDTH = 16;

   // Fixed field widths of the ports.
   localparam int FUNC_W     = 2;
   localparam int ROW_IDX_W  = 6;
   localparam int COL_IDX_W  = 6;
   localparam int OUT_ROW_W  = 6;
   localparam int RES_W      = 32;
   localparam int CFG_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Derived widths.
   localparam int COL_AW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W  = $clog2(MAX_COLS + 1);
   localparam int PROD_W     = 2 * VALUE_WIDTH;
   localparam int ACC_FULL_W = PROD_W + $clog2(MAX_COLS) + 1;
   localparam int ACC_W      = (ACC_FULL_W > 64) ? 64 : ACC_FULL_W;

   // Drain phase length, from the end of the column feed until the row sums are loaded into
   // the result stages; the last cell holds its final sum before that.
   localparam int DRAIN_CYCLES = MAX_ROWS + 4;
   localparam int SEQ_MAX      = (MAX_COLS > DRAIN_CYCLES) ? MAX_COLS : DRAIN_CYCLES;
   localparam int SEQ_W        = $clog2(SEQ_MAX + 1);

   localparam logic [FUNC_W-1:0] FUNC_WRITE_MATRIX = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_VECTOR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE      = 2'd2;

   localparam logic REG_ROWS_IN_USE = 1'b0;
   localparam logic REG_COLS_IN_USE = 1'b1;

   // One vector element travelling down the chain of cells.
   typedef struct packed {
      logic                          valid;
      logic [COL_AW-1:0]             col;
      logic signed [VALUE_WIDTH-1:0] vec;
   } token_type;

   // Broadcast controls from the sequencer to every cell.
   typedef struct packed {
      logic                          clear;
      logic                          load;
      logic                          shift;
      logic [COL_AW-1:0]             wr_addr;
      logic signed [VALUE_WIDTH-1:0] wr_data;
   } cell_ctrl_type;

endpackage

// ===== rtl/mvmu_cell.sv =====
// One row cell of the matrix-vector chain: its matrix row memory, a MAC and a result stage.
// Depends on mvmu_pkg.
module mvmu_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  mvmu_pkg::cell_ctrl_type          ctrl,
   input  logic                             wr_en,
   input  mvmu_pkg::token_type              tok_in,
   output mvmu_pkg::token_type              tok_out,
   input  logic signed [mvmu_pkg::RES_W-1:0] res_next,
   output logic signed [mvmu_pkg::RES_W-1:0] res_out
);
   import mvmu_pkg::*;

   logic signed [VALUE_WIDTH-1:0] row_mem [MAX_COLS];

   logic                          tok_vld_ff;
   logic [COL_AW-1:0]             tok_col_ff;
   logic signed [VALUE_WIDTH-1:0] tok_vec_ff;
   logic signed [VALUE_WIDTH-1:0] mem_q_ff;
   logic signed [VALUE_WIDTH-1:0] vec_ff;
   logic                          mul_vld_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W-1:0]      prod_in;
   logic                          prod_vld_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [ACC_W-1:0]       acc_in;
   logic signed [ACC_W-1:0]       prod_ext;
   logic signed [ACC_W-1:0]       sum;
   logic signed [RES_W-1:0]       res_ff;
   logic signed [RES_W-1:0]       res_in;

   function automatic logic signed [RES_W-1:0] sat_result(input logic signed [ACC_W-1:0] a);
      logic signed [64:0] w;
      w = 65'(a);
      if (w > 65'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (w < -(65'sd2147483648)) begin
         return 32'sh8000_0000;
      end
      return w[RES_W-1:0];
   endfunction

   // Matrix row store: one write port for loads, one registered read for the stream.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      mem_q_ff <= row_mem[tok_in.col];
   end

   assign prod_in  = mem_q_ff * vec_ff;
   assign prod_ext = ACC_W'(prod_ff);
   assign sum      = acc_ff + prod_ext;

   // Saturating add; overflow shows as equal operand signs and a flipped sum sign.
   always_comb begin
      acc_in = sum;
      if ((acc_ff[ACC_W-1] == prod_ext[ACC_W-1]) && (sum[ACC_W-1] != acc_ff[ACC_W-1])) begin
         acc_in = acc_ff[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   always_comb begin
      res_in = res_ff;
      if (ctrl.load) begin
         res_in = sat_result(acc_ff);
      end else if (ctrl.shift) begin
         res_in = res_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_vld_ff  <= 1'b0;
         mul_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         tok_vld_ff  <= tok_in.valid;
         mul_vld_ff  <= tok_in.valid;
         prod_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      tok_col_ff <= tok_in.col;
      tok_vec_ff <= tok_in.vec;
      vec_ff     <= tok_in.vec;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign tok_out = '{valid: tok_vld_ff, col: tok_col_ff, vec: tok_vec_ff};
   assign res_out = res_ff;

endmodule

// ===== rtl/matrix_vector_multiply_unit.sv =====
// Matrix-vector multiply unit: one cell per matrix row; vector elements stream down the
// chain and each cell accumulates its row's dot product. Depends on mvmu_pkg and mvmu_cell.
//
// A matrix or vector write completes as it is taken; the next request may follow at once.
// A compute holds off requests while the vector store, read one element a cycle, feeds the
// chain and the last cell finishes its sum; then the results leave in row order, one per
// cycle when not stalled. During the result phase the request side is stalled until the
// final result transfers, and a request may be taken in that same cycle. Results are Q16.16,
// saturated to 32 bits; a compute with zero rows in use returns nothing. The stores have no
// reset and must be written before they are used.
module matrix_vector_multiply_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [mvmu_pkg::FUNC_W-1:0]              req_func,
   input  logic [mvmu_pkg::ROW_IDX_W-1:0]           req_row_index,
   input  logic [mvmu_pkg::COL_IDX_W-1:0]           req_col_index,
   input  logic signed [mvmu_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [mvmu_pkg::OUT_ROW_W-1:0]           rsp_out_row,
   output logic signed [mvmu_pkg::RES_W-1:0]        rsp_product_sum,
   output logic                                     rsp_last,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [mvmu_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [mvmu_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [mvmu_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);
   import mvmu_pkg::*;
   `include "matrix_vector_multiply_unit_macros.svh"

   typedef enum logic [1:0] {ST_IDLE, ST_FEED, ST_DRAIN, ST_OUTPUT} state_type;

   state_type               state_ff, state_in;
   logic [SEQ_W-1:0]        seq_cnt_ff, seq_cnt_in;
   logic [ROW_CNT_W-1:0]    out_cnt_ff, out_cnt_in;
   logic                    head_vld_ff, head_vld_in;
   logic [COL_AW-1:0]       head_col_ff, head_col_in;
   logic [CFG_W-1:0]        rows_ff, cols_ff;
   logic signed [VALUE_WIDTH-1:0] vec_mem [MAX_COLS];
   logic signed [VALUE_WIDTH-1:0] vec_q_ff;

   logic                    req_accept;
   logic                    rsp_xfer;
   logic                    start;
   logic                    load;
   logic                    shift;
   logic                    col_ok;
   logic                    mat_wr;
   logic                    vec_wr;
   logic                    csr_wr;
   logic [ROW_CNT_W-1:0]    nrows;
   logic [COL_CNT_W-1:0]    ncols;
   cell_ctrl_type           ctrl;
   logic [MAX_ROWS-1:0]     cell_we;
   token_type               tok [MAX_ROWS+1];
   logic signed [RES_W-1:0] res [MAX_ROWS+1];

   assign nrows = (int'(rows_ff) >= MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(rows_ff);
   assign ncols = (int'(cols_ff) >= MAX_COLS) ? COL_CNT_W'(MAX_COLS) : COL_CNT_W'(cols_ff);

   assign rsp_valid       = (state_ff == ST_OUTPUT);
   assign rsp_xfer        = rsp_valid && !rsp_stall;
   assign rsp_last        = ((out_cnt_ff + 1'b1) == nrows);
   assign rsp_out_row     = OUT_ROW_W'(out_cnt_ff);
   assign rsp_product_sum = res[0];

   // Requests wait out the compute and are let in again with the final result transfer.
   assign req_stall  = (state_ff == ST_FEED) || (state_ff == ST_DRAIN) ||
                       ((state_ff == ST_OUTPUT) && !(rsp_last && !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   assign col_ok = (int'(req_col_index) < MAX_COLS);
   assign mat_wr = req_accept && (req_func == FUNC_WRITE_MATRIX) && col_ok;
   assign vec_wr = req_accept && (req_func == FUNC_WRITE_VECTOR) && col_ok;
   assign start  = req_accept && (req_func == FUNC_COMPUTE) && (nrows != '0);

   always_comb begin
      state_in    = state_ff;
      seq_cnt_in  = seq_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      head_vld_in = 1'b0;
      head_col_in = head_col_ff;
      load        = 1'b0;
      shift       = 1'b0;
      case (state_ff)
         ST_FEED: begin
            head_vld_in = 1'b1;
            head_col_in = COL_AW'(seq_cnt_ff);
            if ((seq_cnt_ff + 1'b1) == SEQ_W'(ncols)) begin
               state_in   = ST_DRAIN;
               seq_cnt_in = '0;
            end else begin
               seq_cnt_in = seq_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (seq_cnt_ff == SEQ_W'(DRAIN_CYCLES - 1)) begin
               load       = 1'b1;
               state_in   = ST_OUTPUT;
               out_cnt_in = '0;
            end else begin
               seq_cnt_in = seq_cnt_ff + 1'b1;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               shift = 1'b1;
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  out_cnt_in = out_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (start) begin
         seq_cnt_in = '0;
         state_in   = (ncols == '0) ? ST_DRAIN : ST_FEED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         seq_cnt_ff  <= '0;
         out_cnt_ff  <= '0;
         head_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         seq_cnt_ff  <= seq_cnt_in;
         out_cnt_ff  <= out_cnt_in;
         head_vld_ff <= head_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_col_ff <= head_col_in;
   end

   // Vector store: written by loads, read one element a cycle during the feed.
   always_ff @(posedge clock) begin
      if (vec_wr) begin
         vec_mem[COL_AW'(req_col_index)] <= req_value;
      end
      vec_q_ff <= vec_mem[COL_AW'(seq_cnt_ff)];
   end

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(MAX_ROWS);
         cols_ff <= CFG_W'(MAX_COLS);
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_ROWS_IN_USE: rows_ff <= csr_pwdata[CFG_W-1:0];
            REG_COLS_IN_USE: cols_ff <= csr_pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ROWS_IN_USE: csr_prdata = CSR_DATA_W'(rows_ff);
         REG_COLS_IN_USE: csr_prdata = CSR_DATA_W'(cols_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Chain of row cells.
   assign ctrl = '{clear: start, load: load, shift: shift,
                   wr_addr: COL_AW'(req_col_index), wr_data: req_value};

   assign tok[0]        = '{valid: head_vld_ff, col: head_col_ff, vec: vec_q_ff};
   assign res[MAX_ROWS] = '0;

   for (genvar r = 0; r < MAX_ROWS; r++) begin : g_cell
      assign cell_we[r] = mat_wr && (int'(req_row_index) == r);

      mvmu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_en    (cell_we[r]),
         .tok_in   (tok[r]),
         .tok_out  (tok[r+1]),
         .res_next (res[r+1]),
         .res_out  (res[r])
      );
   end

   `MVMU_ASSERT_NOW(a_row_in_range, rsp_valid, out_cnt_ff < nrows)
   `MVMU_ASSERT_NOW(a_first_row_zero, $rose(rsp_valid), out_cnt_ff == '0)
   `MVMU_ASSERT_NEXT(a_more_results, rsp_xfer && !rsp_last, rsp_valid)
   `MVMU_ASSERT_NEXT(a_compute_starts, start, (state_ff == ST_FEED) || (state_ff == ST_DRAIN))

endmodule

// ===== verif/matrix_vector_multiply_unit_tb.sv =====
// Self-checking testbench for the matrix-vector multiply unit: a directed table, then random
// load and compute phases, all checked against a dot-product predictor kept in this file.
// Depends on mvmu_pkg and the matrix_vector_multiply_unit RTL.
module matrix_vector_multiply_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mvmu_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = MAX_COLS + DRAIN_CYCLES + 4;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 8 * (SETTLE_CYCLES + HOLD_CYCLES);
   localparam int RANDOM_PHASES  = 5;
   localparam int ITEMS_PER_PHASE = 16;
   localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SUM_MIN = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic [OUT_ROW_W-1:0]    out_row;
      logic signed [RES_W-1:0] product_sum;
      logic                    last;
   } row_result_type;

   typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_type;

   typedef struct packed {
      step_kind_type                 kind;
      logic [FUNC_W-1:0]             func;
      logic                          csr_reg;
      logic [ROW_IDX_W-1:0]          row;
      logic [COL_IDX_W-1:0]          col;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          typed;
      logic signed [RES_W-1:0]       typed_sum;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic [ROW_IDX_W-1:0] req_row_index = '0;
   logic [COL_IDX_W-1:0] req_col_index = '0;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_ROW_W-1:0] rsp_out_row;
   logic signed [RES_W-1:0] rsp_product_sum;
   logic rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Predictor state: its own copy of both stores and both registers.
   logic signed [VALUE_WIDTH-1:0] matrix_copy [MAX_ROWS][MAX_COLS];
   logic signed [VALUE_WIDTH-1:0] vector_copy [MAX_COLS];
   bit matrix_loaded [MAX_ROWS][MAX_COLS];
   bit vector_loaded [MAX_COLS];
   logic [CFG_W-1:0] rows_cfg = CFG_W'(64);
   logic [CFG_W-1:0] cols_cfg = CFG_W'(64);

   row_result_type rows_due [$];
   step_type directed [$];
   int mismatch_count = 0;
   int rows_checked = 0;
   int req_burst_left = 0;
   int rsp_burst_left = 0;
   int idle_cycles = 0;

   matrix_vector_multiply_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_product_sum (rsp_product_sum),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Mostly random idle gaps, with occasional runs of back-to-back transfers.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return '0;
         3: return -16'sd1;
         default: return VALUE_WIDTH'($urandom);
      endcase
   endfunction

   function automatic int effective(input logic [CFG_W-1:0] cfg, input int limit);
      return (int'(cfg) > limit) ? limit : int'(cfg);
   endfunction

   function automatic step_type cfg_step(input logic sel, input int val);
      step_type s;
      s = '0;
      s.kind = STEP_CFG;
      s.csr_reg = sel;
      s.value = VALUE_WIDTH'(val);
      return s;
   endfunction

   function automatic step_type item_step(input logic [FUNC_W-1:0] func, input int row,
                                          input int col, input int value, input bit typed = 0,
                                          input logic signed [RES_W-1:0] typed_sum = '0);
      step_type s;
      s = '0;
      s.kind = STEP_ITEM;
      s.func = func;
      s.row = ROW_IDX_W'(row);
      s.col = COL_IDX_W'(col);
      s.value = VALUE_WIDTH'(value);
      s.typed = typed;
      s.typed_sum = typed_sum;
      return s;
   endfunction

   // Updates the stores, or for a compute queues one dot product per row in use. A typed
   // sum, where given, replaces the computed one for every row.
   task automatic predict_dot_products(input logic [FUNC_W-1:0] func,
                                       input logic [ROW_IDX_W-1:0] row,
                                       input logic [COL_IDX_W-1:0] col,
                                       input logic signed [VALUE_WIDTH-1:0] value,
                                       input bit typed, input logic signed [RES_W-1:0] typed_sum);
      int nrows;
      int ncols;
      longint acc;
      row_result_type res;
      case (func)
         FUNC_WRITE_MATRIX: begin
            matrix_copy[row][col] = value;
            matrix_loaded[row][col] = 1'b1;
         end
         FUNC_WRITE_VECTOR: begin
            vector_copy[col] = value;
            vector_loaded[col] = 1'b1;
         end
         FUNC_COMPUTE: begin
            nrows = effective(rows_cfg, MAX_ROWS);
            ncols = effective(cols_cfg, MAX_COLS);
            for (int r = 0; r < nrows; r++) begin
               // At most 64 products of 31 bits each, so a 64-bit sum cannot wrap.
               acc = 0;
               for (int c = 0; c < ncols; c++)
                  acc += longint'(matrix_copy[r][c]) * longint'(vector_copy[c]);
               if (acc > SUM_MAX) acc = SUM_MAX;
               if (acc < SUM_MIN) acc = SUM_MIN;
               res.out_row = OUT_ROW_W'(r);
               res.product_sum = typed ? typed_sum : RES_W'(acc);
               res.last = (r == nrows - 1);
               rows_due.push_back(res);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ROW_IDX_W-1:0] row,
                            input logic [COL_IDX_W-1:0] col,
                            input logic signed [VALUE_WIDTH-1:0] value, input bit typed = 0,
                            input logic signed [RES_W-1:0] typed_sum = '0);
      int gap;
      gap = draw_gap(req_burst_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_row_index <= row;
      req_col_index <= col;
      req_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_dot_products(func, row, col, value, typed, typed_sum);
   endtask

   // Waits until every expected row has transferred, then lets a compute that produces
   // nothing, or a trailing write, run to completion.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic sel, input int val);
      logic [CFG_W-1:0] field;
      logic [CSR_DATA_W-1:0] readback;
      field = CFG_W'(val);
      quiesce();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(sel));
      csr_pwdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (sel == REG_ROWS_IN_USE) rows_cfg = field;
      else cols_cfg = field;
      // Back-to-back read of the same register.
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CSR_DATA_W'(field))
         flag_mismatch($sformatf("register %0d read %0h, wrote %0h", sel, readback, field));
   endtask

   // Result side: random stalls, one long hold-off while requests are still offered.
   initial begin : result_side
      int gap;
      bit held;
      row_result_type want;
      held = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_burst_left);
         if (!held && rows_checked >= 80 && req_valid === 1'b1) begin
            gap = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         rows_checked++;
         if (rows_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result for row %0d", rsp_out_row));
         end else begin
            want = rows_due.pop_front();
            if (rsp_out_row !== want.out_row)
               flag_mismatch($sformatf("out_row %0d, expected %0d", rsp_out_row, want.out_row));
            if (rsp_product_sum !== want.product_sum)
               flag_mismatch($sformatf("row %0d product_sum %0d, expected %0d", want.out_row,
                                       rsp_product_sum, want.product_sum));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("row %0d last %0b, expected %0b", want.out_row,
                                       rsp_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int nrows;
      int ncols;
      int pick;
      directed = '{
         // Zero rows in use: a compute returns nothing, whatever the column count.
         cfg_step(REG_ROWS_IN_USE, 0),
         cfg_step(REG_COLS_IN_USE, 127),
         item_step(FUNC_COMPUTE, 0, 0, 0),
         item_step(FUNC_UNUSED, 63, 63, -32768),
         // Oversized row count with zero columns: 64 rows, each summing to zero.
         cfg_step(REG_ROWS_IN_USE, 127),
         cfg_step(REG_COLS_IN_USE, 0),
         item_step(FUNC_COMPUTE, 0, 0, 0, 1, 32'sh0000_0000),
         // Four largest positive products saturate high.
         cfg_step(REG_ROWS_IN_USE, 1),
         cfg_step(REG_COLS_IN_USE, 4),
         item_step(FUNC_WRITE_MATRIX, 0, 0, -32768),
         item_step(FUNC_WRITE_MATRIX, 0, 1, -32768),
         item_step(FUNC_WRITE_MATRIX, 0, 2, -32768),
         item_step(FUNC_WRITE_MATRIX, 0, 3, -32768),
         item_step(FUNC_WRITE_VECTOR, 0, 0, -32768),
         item_step(FUNC_WRITE_VECTOR, 0, 1, -32768),
         item_step(FUNC_WRITE_VECTOR, 0, 2, -32768),
         item_step(FUNC_WRITE_VECTOR, 0, 3, -32768),
         item_step(FUNC_COMPUTE, 0, 0, 0, 1, 32'sh7FFF_FFFF),
         // Four largest negative products saturate low.
         item_step(FUNC_WRITE_MATRIX, 0, 0, 32767),
         item_step(FUNC_WRITE_MATRIX, 0, 1, 32767),
         item_step(FUNC_WRITE_MATRIX, 0, 2, 32767),
         item_step(FUNC_WRITE_MATRIX, 0, 3, 32767),
         item_step(FUNC_COMPUTE, 0, 0, 0, 1, 32'sh8000_0000),
         item_step(FUNC_WRITE_MATRIX, 63, 63, 1),
         item_step(FUNC_WRITE_VECTOR, 63, 63, -1),
         item_step(FUNC_COMPUTE, 0, 0, 0)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == STEP_CFG)
            write_register(directed[i].csr_reg, int'(directed[i].value));
         else
            send_item(directed[i].func, directed[i].row, directed[i].col, directed[i].value,
                      directed[i].typed, directed[i].typed_sum);
      end

      // Random phases: load every entry a compute will read, then mixed traffic.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin nrows = 4;  ncols = 3; end
            1: begin nrows = 16; ncols = 2; end
            2: begin nrows = 2;  ncols = 9; end
            3: begin nrows = 5;  ncols = 6; end
            default: begin
               nrows = $urandom_range(1, 6);
               ncols = $urandom_range(1, 10);
            end
         endcase
         write_register(REG_ROWS_IN_USE, nrows);
         write_register(REG_COLS_IN_USE, ncols);
         for (int r = 0; r < nrows; r++)
            for (int c = 0; c < ncols; c++)
               if (!matrix_loaded[r][c])
                  send_item(FUNC_WRITE_MATRIX, ROW_IDX_W'(r), COL_IDX_W'(c), draw_value());
         for (int c = 0; c < ncols; c++)
            if (!vector_loaded[c])
               send_item(FUNC_WRITE_VECTOR, ROW_IDX_W'($urandom), COL_IDX_W'(c), draw_value());
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
               send_item(FUNC_WRITE_MATRIX, ROW_IDX_W'($urandom_range(0, nrows - 1)),
                         COL_IDX_W'($urandom_range(0, ncols - 1)), draw_value());
            else if (pick < 60)
               send_item(FUNC_WRITE_MATRIX, ROW_IDX_W'($urandom), COL_IDX_W'($urandom),
                         draw_value());
            else if (pick < 78)
               send_item(FUNC_WRITE_VECTOR, ROW_IDX_W'($urandom),
                         ($urandom_range(0, 3) == 0) ? COL_IDX_W'($urandom)
                                                     : COL_IDX_W'($urandom_range(0, ncols - 1)),
                         draw_value());
            else if (pick < 92)
               send_item(FUNC_COMPUTE, ROW_IDX_W'($urandom), COL_IDX_W'($urandom),
                         VALUE_WIDTH'($urandom));
            else
               send_item(FUNC_UNUSED, ROW_IDX_W'($urandom), COL_IDX_W'($urandom),
                         VALUE_WIDTH'($urandom));
         end
         send_item(FUNC_COMPUTE, ROW_IDX_W'($urandom), COL_IDX_W'($urandom),
                   VALUE_WIDTH'($urandom));
      end

      quiesce();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
